[rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the rational arithmetic unit.
// No dependencies.
package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int PW = 2 * WORD_BITS;   // width of products and sums
  localparam int KW = $clog2(PW);      // counter width over PW steps

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;
  } out_t;

  // one classified item on its way from front to back
  typedef struct packed {
    logic          err;
    logic          zero;
    logic          neg;
    logic [PW-1:0] nmag;
    logic [PW-1:0] dmag;
  } job_t;

endpackage

[rtl/rau_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the rational arithmetic unit.
// Depends on rau_pkg.
interface rau_in_if (input logic clk);
  import rau_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rau_out_if (input logic clk);
  import rau_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/rau_front.sv]
`timescale 1ns / 1ps
// Front end: decodes operands, cross-multiplies and adds, classifies errors.
// Depends on rau_pkg. Three stages that advance together.
module rau_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rau_pkg::in_t  in_data,
  output logic          push,
  input  logic          q_ready,
  output rau_pkg::job_t job
);
  import rau_pkg::*;

  localparam int W = WORD_BITS;

  logic adv;
  logic v1, v2, v3;

  // stage 1: sign and magnitude
  logic [1:0]   mode1;
  logic         err1;
  logic         an_s, ad_s, bn_s, bd_s;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;

  // stage 2: products
  logic [1:0]    mode2;
  logic          err2;
  logic          pa_s, pb_s, pc_s;
  logic [PW-1:0] pa, pb, pc;

  // stage 3: queue entry
  job_t job3;

  logic         sa, sb, sc, sd;
  logic [W-1:0] ma, mb, mc, md;
  logic [W-1:0] opa, opc;
  logic         opa_s, opc_s;
  logic         yneg;
  logic [PW-1:0] nsum;
  logic          nneg;

  function automatic logic [W:0] smag(input logic [31:0] raw);
    logic [W-1:0] v;
    logic         s;
    v = raw[W-1:0];
    s = v[W-1];
    return {s, s ? W'(-v) : v};
  endfunction

  assign adv      = !v3 || q_ready;
  assign in_ready = adv;
  assign push     = v3 && q_ready;
  assign job      = job3;

  assign {sa, ma} = smag(in_data.a_num);
  assign {sb, mb} = smag(in_data.a_den);
  assign {sc, mc} = smag(in_data.b_num);
  assign {sd, md} = smag(in_data.b_den);

  // operand selection for the first and third multiplier
  always_comb begin
    opa   = (mode1 == MODE_MUL) ? bn_m : bd_m;
    opa_s = (mode1 == MODE_MUL) ? bn_s : bd_s;
    opc   = (mode1 == MODE_DIV) ? bn_m : bd_m;
    opc_s = (mode1 == MODE_DIV) ? bn_s : bd_s;
  end

  // signed-magnitude add/subtract of cross products; pa alone for mul/div
  always_comb begin
    yneg = (mode2 == MODE_SUB) ? !pb_s : pb_s;
    if (mode2 == MODE_MUL || mode2 == MODE_DIV) begin
      nsum = pa;
      nneg = pa_s;
    end else if (pa_s == yneg) begin
      nsum = pa + pb;
      nneg = pa_s;
    end else if (pa >= pb) begin
      nsum = pa - pb;
      nneg = pa_s;
    end else begin
      nsum = pb - pa;
      nneg = yneg;
    end
    if (nsum == '0) begin
      nneg = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= in_data.mode;
      err1  <= (mb == '0) || (md == '0) || (in_data.mode == MODE_DIV && mc == '0);
      an_s  <= sa;  an_m <= ma;
      ad_s  <= sb;  ad_m <= mb;
      bn_s  <= sc;  bn_m <= mc;
      bd_s  <= sd;  bd_m <= md;

      mode2 <= mode1;
      err2  <= err1;
      pa    <= PW'(an_m) * PW'(opa);
      pa_s  <= an_s ^ opa_s;
      pb    <= PW'(bn_m) * PW'(ad_m);
      pb_s  <= bn_s ^ ad_s;
      pc    <= PW'(ad_m) * PW'(opc);
      pc_s  <= ad_s ^ opc_s;

      job3.err  <= err2;
      job3.zero <= (nsum == '0);
      job3.neg  <= nneg != pc_s;
      job3.nmag <= nsum;
      job3.dmag <= pc;
    end
  end

endmodule

[rtl/rau_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue between front and back end.
// Depends on rau_pkg.
module rau_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rau_pkg::job_t wr_job,
  output logic          wr_ready,
  output logic          rd_valid,
  input  logic          pop,
  output rau_pkg::job_t rd_job
);
  import rau_pkg::*;

  job_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_job;
    end
  end

endmodule

[rtl/rau_back.sv]
`timescale 1ns / 1ps
// Back end: binary GCD, two-lane restoring division, range check, result register.
// Depends on rau_pkg.
module rau_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          pop,
  input  rau_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output rau_pkg::out_t out_data
);
  import rau_pkg::*;

  localparam int W = WORD_BITS;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GCD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [PW-1:0] LIM = PW'(1) << (W - 1);

  logic [2:0]    state;
  logic          direct;
  logic [1:0]    pre_status;
  logic          neg;
  logic [PW-1:0] x, y, g;
  logic [KW-1:0] k, cnt;
  logic [PW-1:0] qn, qd, rn, rd;
  logic [PW:0]   tn, td;
  logic          ovf;
  logic signed [W-1:0] sval;
  out_t          res;

  assign pop = (state == S_IDLE) && q_valid;
  assign tn  = {rn, qn[PW-1]};
  assign td  = {rd, qd[PW-1]};

  always_comb begin
    ovf  = (qd > LIM - 1) || (qn > (neg ? LIM : LIM - 1));
    sval = neg ? -signed'(qn[W-1:0]) : signed'(qn[W-1:0]);
    res  = '0;
    if (direct) begin
      res.status  = pre_status;
      res.res_den = (pre_status == ST_OK) ? 31'd1 : 31'd0;
    end else if (ovf) begin
      res.status = ST_OVF;
    end else begin
      res.status  = ST_OK;
      res.res_num = 32'(sval);
      res.res_den = 31'(qd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= (job.err || job.zero) ? S_DONE : S_GCD;
          end
        end
        S_GCD: begin
          if (x == '0 || y == '0) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        direct     <= job.err || job.zero;
        pre_status <= job.err ? ST_ZERO : ST_OK;
        neg        <= job.neg;
        x          <= job.nmag;
        y          <= job.dmag;
        qn         <= job.nmag;
        qd         <= job.dmag;
        k          <= '0;
      end
      S_GCD: begin
        if (x == '0 || y == '0) begin
          g   <= (x | y) << k;
          rn  <= '0;
          rd  <= '0;
          cnt <= KW'(PW - 1);
        end else if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + 1'b1;
        end else if (!x[0]) begin
          x <= x >> 1;
        end else if (!y[0]) begin
          y <= y >> 1;
        end else if (x >= y) begin
          x <= x - y;
        end else begin
          y <= y - x;
        end
      end
      S_DIV: begin
        // dividend bits shift out of the top while quotient bits enter below
        cnt <= cnt - 1'b1;
        if (tn >= {1'b0, g}) begin
          rn <= PW'(tn - {1'b0, g});
          qn <= {qn[PW-2:0], 1'b1};
        end else begin
          rn <= tn[PW-1:0];
          qn <= {qn[PW-2:0], 1'b0};
        end
        if (td >= {1'b0, g}) begin
          rd <= PW'(td - {1'b0, g});
          qd <= {qd[PW-2:0], 1'b1};
        end else begin
          rd <= td[PW-1:0];
          qd <= {qd[PW-2:0], 1'b0};
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data <= res;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/rational_arith_unit.sv]
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: front end, queue, back end.
// Depends on rau_pkg, rau_ifs, rau_front, rau_queue, rau_back.
//
// Usage: each beat on req carries a mode (add, subtract, multiply, divide)
// and two fractions a_num/a_den, b_num/b_den. Each produces one beat on rsp
// with the reduced fraction (sign on the numerator, positive denominator)
// and a status: ok, zero denominator / divide by zero, or overflow. On a
// nonzero status both result fields are 0; a zero numerator gives 0/1.
// Flow: three front stages, then the back end runs a binary GCD of the
// 64-bit numerator and denominator (one subtract or shift per cycle, data
// dependent), a two-lane restoring division of both by the GCD, and a load
// of the result register. Errors and zero numerators skip GCD and division.
// Throughput is set by the back end's GCD loop and divider: it takes a new
// item only once the last one is in the result register; the front end and
// a two-entry queue keep accepting while the back end works, so up to seven
// items can be in flight (three front stages, two queue slots, the back end
// and the result register).
// Reset (synchronous, active high) empties all stages and the queue.
// If rsp stalls, the result register holds; the back end waits, the queue
// fills and req.ready drops.
module rational_arith_unit (
  input  logic      clk,
  input  logic      rst,
  rau_in_if.sink    req,
  rau_out_if.source rsp
);
  import rau_pkg::*;

  logic push, q_ready, q_valid, pop;
  job_t fjob, qjob;

  rau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_data  (req.data),
    .push     (push),
    .q_ready  (q_ready),
    .job      (fjob)
  );

  rau_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_job   (fjob),
    .wr_ready (q_ready),
    .rd_valid (q_valid),
    .pop      (pop),
    .rd_job   (qjob)
  );

  rau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop       (pop),
    .job       (qjob),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_data  (rsp.data)
  );

endmodule
